### hw/rtl/kps_pkg.sv
// shared constants, codes and controller/datapath signal groups
// for the keyframe playback sequencer; no dependencies
package kps_pkg;

  localparam int unsigned KF_DEPTH = 32;
  localparam int unsigned KF_AW    = (KF_DEPTH > 1) ? $clog2(KF_DEPTH) : 1;
  localparam int unsigned KF_CW    = $clog2(KF_DEPTH + 1);

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_PLAY   = 3'd4;
  localparam logic [2:0] OP_STOP   = 3'd5;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_MOVING = 3'd1;
  localparam logic [2:0] PH_GRAB   = 3'd2;
  localparam logic [2:0] PH_DROP   = 3'd3;
  localparam logic [2:0] PH_WAIT   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic [1:0] KT_GRAB = 2'd1;
  localparam logic [1:0] KT_DROP = 2'd2;

  localparam logic [1:0] CLAW_NONE = 2'd0;
  localparam logic [1:0] CLAW_SET  = 2'd1;
  localparam logic [1:0] CLAW_OPEN = 2'd2;

  localparam logic REG_SETTLE = 1'b0;
  localparam logic REG_CLAW   = 1'b1;

  typedef struct packed {
    logic accept;
    logic eval;
    logic move;
  } kps_cmd_t;

  typedef struct packed {
    logic need_move;
  } kps_sts_t;

endpackage

### hw/rtl/kps_ctrl.sv
// sequencing state machine: accept, evaluate, optional second table read
// depends on kps_pkg
module kps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  kps_pkg::kps_sts_t sts,
  output kps_pkg::kps_cmd_t cmd,
  output logic              busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = sts.need_move ? S_MOVE : S_IDLE;
      end
      S_MOVE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.accept = start && (state_r == S_IDLE);
  assign cmd.eval   = (state_r == S_EVAL);
  assign cmd.move   = (state_r == S_MOVE);

endmodule

### hw/rtl/kps_datapath.sv
// keyframe tables, player registers, item evaluation and result registers
// depends on kps_pkg
module kps_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  kps_pkg::kps_cmd_t        cmd,
  output kps_pkg::kps_sts_t        sts,
  input  logic [15:0]              settle_ms,
  input  logic [15:0]              claw_wait_ms,
  input  logic [2:0]               in_opcode,
  input  logic [31:0]              in_now_ms,
  input  logic                     in_at_target,
  input  logic                     in_estop,
  input  logic [2:0]               in_kf_type,
  input  logic signed [15:0]       in_pos_x,
  input  logic signed [15:0]       in_pos_y,
  input  logic signed [15:0]       in_pos_z,
  input  logic signed [15:0]       in_tilt,
  input  logic [1:0]               in_tool_sel,
  input  logic signed [12:0]       in_grip_ticks,
  input  logic [15:0]              in_hold_ms,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic                     out_is_playing,
  output logic [kps_pkg::KF_CW-1:0] out_frame_count,
  output logic                     out_stop_motion,
  output logic                     out_move_valid,
  output logic [1:0]               out_tool,
  output logic signed [15:0]       out_x,
  output logic signed [15:0]       out_y,
  output logic signed [15:0]       out_z,
  output logic signed [15:0]       out_tilt,
  output logic [1:0]               out_claw_action,
  output logic [11:0]              out_claw_value
);

  localparam int unsigned AW = kps_pkg::KF_AW;
  localparam int unsigned CW = kps_pkg::KF_CW;

  // latched item
  logic [2:0]  op_r;
  logic [31:0] now_r;
  logic        at_tgt_r;
  logic        estop_r;
  logic [2:0]  type_r;
  logic [63:0] pose_in_r;
  logic [1:0]  tool_r;
  logic [12:0] grip_r;
  logic [15:0] hold_r;

  // keyframe tables
  logic [63:0] pose_mem [kps_pkg::KF_DEPTH];
  logic [32:0] act_mem  [kps_pkg::KF_DEPTH];
  logic [63:0] rd_pose_r;
  logic [32:0] rd_act_r;
  logic [AW-1:0] rd_addr;

  // player state
  logic [CW-1:0] count_r, count_nxt;
  logic          playing_r, playing_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [31:0]   start_r, start_nxt;

  // evaluation results
  logic        wr_en;
  logic        need_move;
  logic [1:0]  res_status;
  logic        res_stop;
  logic        res_move;
  logic [1:0]  res_claw;
  logic [11:0] res_claw_val;

  logic [31:0]   elapsed;
  logic [1:0]    a_type;
  logic [12:0]   a_grip;
  logic [15:0]   a_hold;
  logic [15:0]   wait_ms;
  logic [CW-1:0] idx_inc;

  assign elapsed = now_r - start_r;
  assign a_type  = rd_act_r[1:0];
  assign a_grip  = rd_act_r[16:4];
  assign a_hold  = rd_act_r[32:17];
  assign wait_ms = (claw_wait_ms > a_hold) ? claw_wait_ms : a_hold;
  assign idx_inc = idx_r + CW'(1);

  always_comb begin
    count_nxt    = count_r;
    playing_nxt  = playing_r;
    idx_nxt      = idx_r;
    phase_nxt    = phase_r;
    start_nxt    = start_r;
    wr_en        = 1'b0;
    need_move    = 1'b0;
    res_status   = kps_pkg::ST_OK;
    res_stop     = 1'b0;
    res_move     = 1'b0;
    res_claw     = kps_pkg::CLAW_NONE;
    res_claw_val = '0;
    unique case (op_r)
      kps_pkg::OP_TICK: begin
        if (playing_r) begin
          if (estop_r || (idx_r >= count_r)) begin
            playing_nxt = 1'b0;
            idx_nxt     = '0;
            phase_nxt   = kps_pkg::PH_IDLE;
          end else begin
            case (phase_r)
              kps_pkg::PH_MOVING: begin
                if (at_tgt_r || (elapsed > {16'd0, settle_ms})) begin
                  if (a_type == kps_pkg::KT_GRAB) begin
                    phase_nxt = kps_pkg::PH_GRAB;
                  end else if (a_type == kps_pkg::KT_DROP) begin
                    phase_nxt = kps_pkg::PH_DROP;
                  end else begin
                    phase_nxt = kps_pkg::PH_WAIT;
                    start_nxt = now_r;
                  end
                end
              end
              kps_pkg::PH_GRAB: begin
                if (!a_grip[12]) begin
                  res_claw     = kps_pkg::CLAW_SET;
                  res_claw_val = a_grip[11:0];
                end
                phase_nxt = kps_pkg::PH_WAIT;
                start_nxt = now_r;
              end
              kps_pkg::PH_DROP: begin
                res_claw  = kps_pkg::CLAW_OPEN;
                phase_nxt = kps_pkg::PH_WAIT;
                start_nxt = now_r;
              end
              kps_pkg::PH_WAIT: begin
                if (elapsed >= {16'd0, wait_ms}) begin
                  idx_nxt = idx_inc;
                  if (idx_inc >= count_r) begin
                    phase_nxt = kps_pkg::PH_DONE;
                  end else begin
                    phase_nxt = kps_pkg::PH_MOVING;
                    start_nxt = now_r;
                    need_move = 1'b1;
                  end
                end
              end
              default: begin
                playing_nxt = 1'b0;
                idx_nxt     = '0;
                phase_nxt   = kps_pkg::PH_IDLE;
              end
            endcase
          end
        end
      end
      kps_pkg::OP_APPEND: begin
        if (type_r[2]) begin
          res_status = kps_pkg::ST_INVALID;
        end else if (count_r >= CW'(kps_pkg::KF_DEPTH)) begin
          res_status = kps_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      kps_pkg::OP_DELETE: begin
        if (count_r == '0) begin
          res_status = kps_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      kps_pkg::OP_CLEAR: begin
        playing_nxt = 1'b0;
        idx_nxt     = '0;
        phase_nxt   = kps_pkg::PH_IDLE;
        count_nxt   = '0;
      end
      kps_pkg::OP_PLAY: begin
        if (count_r == '0) begin
          res_status = kps_pkg::ST_EMPTY;
        end else begin
          res_stop    = 1'b1;
          res_move    = 1'b1;
          playing_nxt = 1'b1;
          idx_nxt     = '0;
          phase_nxt   = kps_pkg::PH_MOVING;
          start_nxt   = now_r;
        end
      end
      kps_pkg::OP_STOP: begin
        playing_nxt = 1'b0;
        idx_nxt     = '0;
        phase_nxt   = kps_pkg::PH_IDLE;
      end
      default: begin
      end
    endcase
  end

  assign sts.need_move = need_move;

  // read the current entry on accept (entry 0 for a play), the next one while evaluating
  always_comb begin
    if (cmd.eval) begin
      rd_addr = idx_inc[AW-1:0];
    end else if (in_opcode == kps_pkg::OP_PLAY) begin
      rd_addr = '0;
    end else begin
      rd_addr = idx_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.eval) begin
      rd_pose_r <= pose_mem[rd_addr];
      rd_act_r  <= act_mem[rd_addr];
    end
    if (cmd.eval && wr_en) begin
      pose_mem[count_r[AW-1:0]] <= pose_in_r;
      act_mem[count_r[AW-1:0]]  <= {hold_r, grip_r, tool_r, type_r[1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_opcode;
      now_r     <= in_now_ms;
      at_tgt_r  <= in_at_target;
      estop_r   <= in_estop;
      type_r    <= in_kf_type;
      pose_in_r <= {in_tilt, in_pos_z, in_pos_y, in_pos_x};
      tool_r    <= in_tool_sel;
      grip_r    <= in_grip_ticks;
      hold_r    <= in_hold_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      playing_r <= 1'b0;
      idx_r     <= '0;
      phase_r   <= kps_pkg::PH_IDLE;
      start_r   <= '0;
    end else if (cmd.eval) begin
      count_r   <= count_nxt;
      playing_r <= playing_nxt;
      idx_r     <= idx_nxt;
      phase_r   <= phase_nxt;
      start_r   <= start_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (cmd.eval && !need_move) || cmd.move;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      out_status      <= res_status;
      out_is_playing  <= playing_nxt;
      out_frame_count <= count_nxt;
      out_stop_motion <= res_stop;
      out_move_valid  <= res_move;
      out_tool        <= res_move ? rd_act_r[3:2] : 2'd0;
      out_x           <= res_move ? rd_pose_r[15:0]  : 16'sd0;
      out_y           <= res_move ? rd_pose_r[31:16] : 16'sd0;
      out_z           <= res_move ? rd_pose_r[47:32] : 16'sd0;
      out_tilt        <= res_move ? rd_pose_r[63:48] : 16'sd0;
      out_claw_action <= res_claw;
      out_claw_value  <= res_claw_val;
    end else if (cmd.move) begin
      out_move_valid <= 1'b1;
      out_tool       <= rd_act_r[3:2];
      out_x          <= rd_pose_r[15:0];
      out_y          <= rd_pose_r[31:16];
      out_z          <= rd_pose_r[47:32];
      out_tilt       <= rd_pose_r[63:48];
    end
  end

endmodule

### hw/rtl/keyframe_playback_sequencer.sv
// top level of the keyframe playback sequencer: register port, controller
// and datapath; depends on kps_pkg, kps_ctrl and kps_datapath
//
// An item is taken when start is high and busy is low. Every item gives
// exactly one result, shown for a single cycle with out_valid high; the
// receiver cannot stall it. The result is registered in the evaluate state
// or, for a tick that moves on to the next keyframe, in the move state,
// as the keyframe table is read once per cycle through one registered
// read port and the new pose needs a second read. busy stays high until
// the result is shown, so a new item may be started in the cycle its
// predecessor's result is shown, and not before. The two timing registers
// are written through the APB port and should change only when idle.
module keyframe_playback_sequencer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_opcode,
  input  logic [31:0]               in_now_ms,
  input  logic                      in_at_target,
  input  logic                      in_estop,
  input  logic [2:0]                in_kf_type,
  input  logic signed [15:0]        in_pos_x,
  input  logic signed [15:0]        in_pos_y,
  input  logic signed [15:0]        in_pos_z,
  input  logic signed [15:0]        in_tilt,
  input  logic [1:0]                in_tool_sel,
  input  logic signed [12:0]        in_grip_ticks,
  input  logic [15:0]               in_hold_ms,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic                      out_is_playing,
  output logic [kps_pkg::KF_CW-1:0] out_frame_count,
  output logic                      out_stop_motion,
  output logic                      out_move_valid,
  output logic [1:0]                out_tool,
  output logic signed [15:0]        out_x,
  output logic signed [15:0]        out_y,
  output logic signed [15:0]        out_z,
  output logic signed [15:0]        out_tilt,
  output logic [1:0]                out_claw_action,
  output logic [11:0]               out_claw_value
);

  logic [15:0]       cfg_settle_r;
  logic [15:0]       cfg_claw_wait_r;
  logic              cfg_wr;
  kps_pkg::kps_cmd_t cmd;
  kps_pkg::kps_sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_settle_r    <= 16'd3000;
      cfg_claw_wait_r <= 16'd300;
    end else if (cfg_wr) begin
      if (paddr[2] == kps_pkg::REG_CLAW) begin
        cfg_claw_wait_r <= pwdata[15:0];
      end else begin
        cfg_settle_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == kps_pkg::REG_SETTLE) ? {16'd0, cfg_settle_r}
                                                    : {16'd0, cfg_claw_wait_r};

  kps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  kps_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .settle_ms       (cfg_settle_r),
    .claw_wait_ms    (cfg_claw_wait_r),
    .in_opcode       (in_opcode),
    .in_now_ms       (in_now_ms),
    .in_at_target    (in_at_target),
    .in_estop        (in_estop),
    .in_kf_type      (in_kf_type),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_tilt         (in_tilt),
    .in_tool_sel     (in_tool_sel),
    .in_grip_ticks   (in_grip_ticks),
    .in_hold_ms      (in_hold_ms),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_is_playing  (out_is_playing),
    .out_frame_count (out_frame_count),
    .out_stop_motion (out_stop_motion),
    .out_move_valid  (out_move_valid),
    .out_tool        (out_tool),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_tilt        (out_tilt),
    .out_claw_action (out_claw_action),
    .out_claw_value  (out_claw_value)
  );

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after item transfer");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_count <= kps_pkg::KF_CW'(kps_pkg::KF_DEPTH)))
    else $error("frame count beyond table depth");

  a_move_without_claw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_move_valid) |-> (out_claw_action == kps_pkg::CLAW_NONE))
    else $error("pose command and claw action in one result");
`endif

endmodule
